// ----- rtl/assert_macros.svh -----
// assertion macros used by the top rtl file of the pixel format converter
// no dependencies; take it in with an include of the bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define PBR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every rising edge, reset included
`define PBR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/pbr_pkg.sv -----
// shared widths, types, register codes and scaling constants of the pixel converter
// no dependencies; imported by every other rtl file but assert_macros.svh
package pbr_pkg;

  localparam int unsigned PIX_W   = 32;
  localparam int unsigned CH_W    = 8;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned CFG_DW  = 8;
  localparam int unsigned BPP_W   = 3;
  localparam int unsigned OFF_W   = 5;
  localparam int unsigned LEN_W   = 6;
  localparam int unsigned N_W     = 3;
  localparam int unsigned P_W     = 15;
  localparam int unsigned RECIP_W = 17;
  localparam int unsigned PROD_W  = P_W + RECIP_W;
  localparam int unsigned R_W     = 16;
  localparam int unsigned SCALE_SHIFT = 16;

  typedef enum logic [IDX_W-1:0] {
    REG_BPP       = 3'd0,
    REG_RED_OFF   = 3'd1,
    REG_RED_LEN   = 3'd2,
    REG_GREEN_OFF = 3'd3,
    REG_GREEN_LEN = 3'd4,
    REG_BLUE_OFF  = 3'd5,
    REG_BLUE_LEN  = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [OFF_W-1:0] offset;
    logic [LEN_W-1:0] length;
  } comp_cfg_t;

  typedef struct packed {
    logic [BPP_W-1:0] bpp;
    comp_cfg_t        red;
    comp_cfg_t        green;
    comp_cfg_t        blue;
  } cfg_t;

  // load enables of the stages inside a component pipe
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
  } pipe_en_t;

  localparam logic [BPP_W-1:0] BPP_RESET       = 3'd4;
  localparam logic [OFF_W-1:0] RED_OFF_RESET   = 5'd16;
  localparam logic [OFF_W-1:0] GREEN_OFF_RESET = 5'd8;
  localparam logic [OFF_W-1:0] BLUE_OFF_RESET  = 5'd0;
  localparam logic [LEN_W-1:0] LEN_RESET       = 6'd8;
  localparam logic [LEN_W-1:0] LEN_FULL        = 6'd32;
  localparam logic [LEN_W-1:0] LEN_BYTE        = 6'd8;

  // floor(2^16 / (2^n - 1)) for field lengths 1..7, entry zero unused
  localparam logic [RECIP_W-1:0] RECIP [8] = '{
    17'd0,
    17'((2**SCALE_SHIFT) / 1),
    17'((2**SCALE_SHIFT) / 3),
    17'((2**SCALE_SHIFT) / 7),
    17'((2**SCALE_SHIFT) / 15),
    17'((2**SCALE_SHIFT) / 31),
    17'((2**SCALE_SHIFT) / 63),
    17'((2**SCALE_SHIFT) / 127)
  };

endpackage

// ----- rtl/pbr_if.sv -----
// valid/ready channel interfaces: raw pixel in, rgb888 out, register writes
// depends on pbr_pkg
interface pbr_pix_if;
  import pbr_pkg::*;
  logic            valid;
  logic            ready;
  logic [PIX_W-1:0] raw_pixel;
  modport source (output valid, output raw_pixel, input ready);
  modport sink   (input valid, input raw_pixel, output ready);
endinterface

interface pbr_rgb_if;
  import pbr_pkg::*;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red_out;
  logic [CH_W-1:0] green_out;
  logic [CH_W-1:0] blue_out;
  modport source (output valid, output red_out, output green_out, output blue_out,
                  input ready);
  modport sink   (input valid, input red_out, input green_out, input blue_out,
                  output ready);
endinterface

interface pbr_cfg_if;
  import pbr_pkg::*;
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  index;
  logic [CFG_DW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/pbr_cfg_regs.sv -----
// configuration register file of the pixel converter
// depends on pbr_pkg and pbr_if
module pbr_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  pbr_cfg_if.sink       cfg_i,
  output pbr_pkg::cfg_t cfg_o
);
  import pbr_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_BPP:       cfg_d.bpp          = cfg_i.data[BPP_W-1:0];
        REG_RED_OFF:   cfg_d.red.offset   = cfg_i.data[OFF_W-1:0];
        REG_RED_LEN:   cfg_d.red.length   = cfg_i.data[LEN_W-1:0];
        REG_GREEN_OFF: cfg_d.green.offset = cfg_i.data[OFF_W-1:0];
        REG_GREEN_LEN: cfg_d.green.length = cfg_i.data[LEN_W-1:0];
        REG_BLUE_OFF:  cfg_d.blue.offset  = cfg_i.data[OFF_W-1:0];
        REG_BLUE_LEN:  cfg_d.blue.length  = cfg_i.data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bpp          <= BPP_RESET;
      cfg_q.red.offset   <= RED_OFF_RESET;
      cfg_q.red.length   <= LEN_RESET;
      cfg_q.green.offset <= GREEN_OFF_RESET;
      cfg_q.green.length <= LEN_RESET;
      cfg_q.blue.offset  <= BLUE_OFF_RESET;
      cfg_q.blue.length  <= LEN_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/pbr_comp.sv -----
// one colour component: field extract, then scale up or shift down to eight bits
// depends on pbr_pkg; stages two to four of the converter pipeline
module pbr_comp (
  input  logic                       clk_i,
  input  pbr_pkg::pipe_en_t          en_i,
  input  logic [pbr_pkg::PIX_W-1:0]  word_i,
  input  pbr_pkg::comp_cfg_t         cfg_i,
  output logic [pbr_pkg::CH_W-1:0]   comp_o
);
  import pbr_pkg::*;

  // stage two: shift and mask
  logic [LEN_W-1:0] len_c;
  logic [PIX_W-1:0] mask, field_d, field_q;
  logic [LEN_W-1:0] len2_q;

  always_comb begin
    len_c = (cfg_i.length > LEN_FULL) ? LEN_FULL : cfg_i.length;
    if (len_c == LEN_FULL) begin
      mask = '1;
    end else begin
      mask = (PIX_W'(1) << len_c[4:0]) - PIX_W'(1);
    end
    field_d = (word_i >> cfg_i.offset) & mask;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      field_q <= field_d;
      len2_q  <= len_c;
    end
  end

  // stage three: short fields get v*255 times reciprocal, long ones shift down
  logic              small_d, small3_q;
  logic [P_W-1:0]    p_d, p3_q;
  logic [PROD_W-1:0] prod_d, prod3_q;
  logic [LEN_W-1:0]  sh;
  logic [CH_W-1:0]   byte_d, byte3_q;
  logic [N_W-1:0]    n3_q;

  always_comb begin
    small_d = (len2_q[LEN_W-1:N_W] == '0) && (len2_q[N_W-1:0] != '0);
    p_d     = (P_W'(field_q[6:0]) << CH_W) - P_W'(field_q[6:0]);
    prod_d  = PROD_W'(p_d) * PROD_W'(RECIP[len2_q[N_W-1:0]]);
    sh      = len2_q - LEN_BYTE;
    if (len2_q[LEN_W-1:N_W] != '0) begin
      byte_d = CH_W'(field_q >> sh);
    end else begin
      byte_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      small3_q <= small_d;
      p3_q     <= p_d;
      prod3_q  <= prod_d;
      byte3_q  <= byte_d;
      n3_q     <= len2_q[N_W-1:0];
    end
  end

  // stage four: estimate is exact or one low, fix with one compare
  logic [CH_W-1:0] q0, q;
  logic [R_W-1:0]  qd, rem, div;
  logic [CH_W-1:0] comp_d, comp_q;

  always_comb begin
    q0  = prod3_q[SCALE_SHIFT +: CH_W];
    qd  = (R_W'(q0) << n3_q) - R_W'(q0);
    rem = R_W'(p3_q) - qd;
    div = (R_W'(1) << n3_q) - R_W'(1);
    q   = (rem >= div) ? q0 + CH_W'(1) : q0;
    comp_d = small3_q ? q : byte3_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s4) begin
      comp_q <= comp_d;
    end
  end

  assign comp_o = comp_q;

endmodule

// ----- rtl/pixel_bitfield_to_rgb888.sv -----
// Framebuffer pixel word to RGB888 converter, top level.
// Depends on pbr_pkg, pbr_if, pbr_cfg_regs, pbr_comp and assert_macros.svh.
//
// Channels: in_pix_i carries one raw pixel word a transfer, assembled
// little-endian; out_rgb_o carries red, green and blue at eight bits each;
// cfg_i writes the seven format registers (bytes per pixel, then offset and
// length of red, green, blue) and is always ready. Write it only while no
// word is in flight.
// Pipeline: a taken word passes four register stages in turn: byte mask,
// field extract, reciprocal multiply, correction into the output register.
// Throughput: one word a cycle unless stalled; multiply stage sets the clock.
// Reset: valid flags of all stages clear, registers return to a 32-bit
// xRGB layout (four bytes, red at 16, green at 8, blue at 0, eight bits each).
// Stall: when out_rgb_o is held off, stages advance into empty slots ahead,
// so new words are still taken until all four stages hold a word; only then
// does in_pix_i drop ready. Nothing is lost or repeated.
`include "assert_macros.svh"

module pixel_bitfield_to_rgb888 (
  input  logic      clk_i,
  input  logic      rst_ni,
  pbr_pix_if.sink   in_pix_i,
  pbr_rgb_if.source out_rgb_o,
  pbr_cfg_if.sink   cfg_i
);
  import pbr_pkg::*;

  cfg_t     cfg;
  pipe_en_t en;
  logic     en1;
  logic     v1_q, v2_q, v3_q, v4_q;
  logic     v1_d, v2_d, v3_d, v4_d;

  pbr_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // a stage loads when it is empty or its contents move on
  always_comb begin
    en.s4 = !v4_q || out_rgb_o.ready;
    en.s3 = !v3_q || en.s4;
    en.s2 = !v2_q || en.s3;
    en1   = !v1_q || en.s2;
    v1_d  = en1   ? in_pix_i.valid : v1_q;
    v2_d  = en.s2 ? v1_q : v2_q;
    v3_d  = en.s3 ? v2_q : v3_q;
    v4_d  = en.s4 ? v3_q : v4_q;
  end

  assign in_pix_i.ready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
      v4_q <= v4_d;
    end
  end

  // stage one: keep only the valid low bytes
  logic [PIX_W-1:0] byte_mask, word_q;

  always_comb begin
    unique case (cfg.bpp)
      3'd0:    byte_mask = '0;
      3'd1:    byte_mask = PIX_W'(32'h0000_00ff);
      3'd2:    byte_mask = PIX_W'(32'h0000_ffff);
      3'd3:    byte_mask = PIX_W'(32'h00ff_ffff);
      default: byte_mask = '1;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      word_q <= in_pix_i.raw_pixel & byte_mask;
    end
  end

  pbr_comp u_red (
    .clk_i  (clk_i),
    .en_i   (en),
    .word_i (word_q),
    .cfg_i  (cfg.red),
    .comp_o (out_rgb_o.red_out)
  );

  pbr_comp u_green (
    .clk_i  (clk_i),
    .en_i   (en),
    .word_i (word_q),
    .cfg_i  (cfg.green),
    .comp_o (out_rgb_o.green_out)
  );

  pbr_comp u_blue (
    .clk_i  (clk_i),
    .en_i   (en),
    .word_i (word_q),
    .cfg_i  (cfg.blue),
    .comp_o (out_rgb_o.blue_out)
  );

  assign out_rgb_o.valid = v4_q;

  `PBR_ASSERT(a_full_when_blocked, clk_i, rst_ni, !in_pix_i.ready |-> (v1_q && v2_q && v3_q && v4_q), "input held off with an empty stage")
  `PBR_ASSERT(a_take_lands, clk_i, rst_ni, (in_pix_i.valid && in_pix_i.ready) |=> v1_q, "accepted word missing from first stage")
  `PBR_ASSERT(a_stall_holds, clk_i, rst_ni, (v3_q && !en.s3) |=> v3_q, "stalled word dropped from multiply stage")
  `PBR_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !out_rgb_o.valid, "result shown during reset")

endmodule
